// ----- hdl/hcbd_pkg.sv -----
// ----------------------------------------------------------------------------
// hcbd_pkg
// shared types, codes and helpers for the chunked body decoder
// ----------------------------------------------------------------------------
`default_nettype none

package hcbd_pkg;

	// parser phase codes
	typedef enum logic [2:0] {
		PH_HEAD_CR = 3'd0,
		PH_HEAD_LF = 3'd1,
		PH_DIGITS  = 3'd2,
		PH_SIZE_LF = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_DONE    = 3'd5,
		PH_ERROR   = 3'd6
	} phase_t;

	// result kind codes
	typedef enum logic [1:0] {
		KIND_FRAME = 2'd0,
		KIND_DATA  = 2'd1,
		KIND_END   = 2'd2,
		KIND_ERR   = 2'd3
	} kind_t;

	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam int         HEX_BITS  = 4;
	localparam logic [3:0] DIGIT_MAX = 4'hF;

	// parser control state, size counter travels beside it
	typedef struct packed {
		phase_t     phase;
		logic [3:0] digit_count;
	} ctl_t;

	// hex digit decode: {is_hex, value}
	typedef struct packed {
		logic                is_hex;
		logic [HEX_BITS-1:0] value;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		logic [7:0] d;
		h = '0;
		d = '0;
		if (c inside {[8'h30:8'h39]}) begin
			d = c - 8'h30;
			h.is_hex = 1'b1;
		end else if (c inside {[8'h61:8'h66]}) begin
			d = c - 8'h57;
			h.is_hex = 1'b1;
		end else if (c inside {[8'h41:8'h46]}) begin
			d = c - 8'h37;
			h.is_hex = 1'b1;
		end
		h.value = d[HEX_BITS-1:0];
		return h;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/http_chunked_body_decoder.sv -----
// path: a byte accepted on in_* passes two register stages (input register, result
//   register) on its way to its result beat on out_*; a low out_ready stalls it
// throughput: one byte per cycle while out_ready is high; one parser pass per byte
// reset (arst_n low, asynchronous): both stages empty, parser waits for the
//   leading cr, size counter and digit count cleared
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// strips chunked transfer framing from a request body, one byte per beat,
// and reports framing, payload, end of body or a sticky error for each byte
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_body_decoder import hcbd_pkg::*; #(
	parameter int SIZE_BITS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] body_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      out_kind,
	output logic [7:0]      payload_byte
);

	// input register stage
	logic                 valid_s1;
	logic [7:0]           byte_s1;

	// parser state
	ctl_t                 ctl_q;
	logic [SIZE_BITS-1:0] bytes_left_q;

	// result register stage
	logic                 valid_s2;
	logic [1:0]           kind_s2;
	logic [7:0]           data_s2;

	// step outputs
	ctl_t                 ctl_nxt;
	logic [SIZE_BITS-1:0] bytes_left_nxt;
	kind_t                kind;
	logic [7:0]           data;

	logic                 advance;

	// the held byte moves on when the result register is free or draining
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	// input stage takes a new beat whenever it is empty or emptying
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= body_byte;
		end
	end

	// framing decode for the held byte against the current parser state
	hcbd_step #(
		.SIZE_BITS(SIZE_BITS)
	) u_step (
		.ctl           (ctl_q),
		.bytes_left    (bytes_left_q),
		.body_byte     (byte_s1),
		.ctl_nxt       (ctl_nxt),
		.bytes_left_nxt(bytes_left_nxt),
		.kind          (kind),
		.data          (data)
	);

	// parser state commits only when the byte actually advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.phase       <= PH_HEAD_CR;
			ctl_q.digit_count <= '0;
			bytes_left_q      <= '0;
		end else if (advance) begin
			ctl_q        <= ctl_nxt;
			bytes_left_q <= bytes_left_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_s2 <= kind;
			data_s2 <= data;
		end
	end

	assign out_valid    = valid_s2;
	assign out_kind     = kind_s2;
	assign payload_byte = data_s2;

endmodule

`default_nettype wire

// ----- hdl/hcbd_step.sv -----
// ----------------------------------------------------------------------------
// hcbd_step
// one byte of chunk framing: next parser state and the result beat
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_step import hcbd_pkg::*; #(
	parameter int SIZE_BITS = 32
) (
	input  wire ctl_t                 ctl,
	input  wire logic [SIZE_BITS-1:0] bytes_left,
	input  wire logic [7:0]           body_byte,
	output ctl_t                      ctl_nxt,
	output logic [SIZE_BITS-1:0]      bytes_left_nxt,
	output kind_t                     kind,
	output logic [7:0]                data
);

	hex_t hex;

	assign hex = hex_decode(body_byte);

	always_comb begin
		ctl_nxt        = ctl;
		bytes_left_nxt = bytes_left;
		kind           = KIND_FRAME;
		data           = '0;
		case (ctl.phase)
			PH_HEAD_CR: begin
				if (body_byte == CH_CR) begin
					ctl_nxt.phase = PH_HEAD_LF;
				end else begin
					ctl_nxt.phase = PH_ERROR;
					kind          = KIND_ERR;
				end
			end
			PH_HEAD_LF: begin
				if (body_byte != CH_LF) begin
					ctl_nxt.phase = PH_ERROR;
					kind          = KIND_ERR;
				end else if (ctl.digit_count != '0) begin
					// lf after the zero-size head closes the body
					ctl_nxt.phase = PH_DONE;
					kind          = KIND_END;
				end else begin
					ctl_nxt.phase  = PH_DIGITS;
					bytes_left_nxt = '0;
				end
			end
			PH_DIGITS: begin
				if (body_byte == CH_CR) begin
					if (ctl.digit_count == '0) begin
						ctl_nxt.phase = PH_ERROR;
						kind          = KIND_ERR;
					end else begin
						ctl_nxt.phase = PH_SIZE_LF;
					end
				end else if (!hex.is_hex) begin
					ctl_nxt.phase = PH_ERROR;
					kind          = KIND_ERR;
				end else if (bytes_left[SIZE_BITS-1 -: HEX_BITS] != '0) begin
					// next digit would shift bits out of the counter
					ctl_nxt.phase = PH_ERROR;
					kind          = KIND_ERR;
				end else begin
					bytes_left_nxt = {bytes_left[SIZE_BITS-HEX_BITS-1:0], hex.value};
					if (ctl.digit_count != DIGIT_MAX) begin
						ctl_nxt.digit_count = ctl.digit_count + 4'd1;
					end
				end
			end
			PH_SIZE_LF: begin
				if (body_byte != CH_LF) begin
					ctl_nxt.phase = PH_ERROR;
					kind          = KIND_ERR;
				end else if (bytes_left == '0) begin
					ctl_nxt.phase = PH_HEAD_CR;
				end else begin
					ctl_nxt.phase = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				kind           = KIND_DATA;
				data           = body_byte;
				bytes_left_nxt = bytes_left - SIZE_BITS'(1);
				if (bytes_left == SIZE_BITS'(1)) begin
					ctl_nxt.phase       = PH_HEAD_CR;
					ctl_nxt.digit_count = '0;
				end
			end
			PH_DONE: begin
				kind = KIND_END;
			end
			default: begin
				ctl_nxt.phase = PH_ERROR;
				kind          = KIND_ERR;
			end
		endcase
	end

endmodule

`default_nettype wire
